// ===== hdl/tfd_pkg.sv =====
// tfd_pkg: shared constants, codes and types of the thermal frame deframer
`timescale 1ns / 1ps
`default_nettype none

package tfd_pkg;

    // frame geometry of the sensor module
    localparam int COLUMNS        = 32;
    localparam int ROWS           = 24;
    localparam int FRAME_BYTES    = 1544;
    localparam int PIXEL_START    = 4;
    localparam int AMBIENT_START  = 1540;
    localparam int CHECKSUM_START = 1542;
    localparam int NUM_PIXELS     = COLUMNS * ROWS;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 11;
    localparam int SUM_W       = 16;
    localparam int VAL_W       = 16;
    localparam int PIX_IDX_W   = 10;
    localparam int COL_W       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W       = $clog2(ROWS + 1);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h5A;

    // byte positions inside a frame, sync bytes included
    localparam logic [POS_W-1:0] POS_PIXEL_START = POS_W'(PIXEL_START);
    localparam logic [POS_W-1:0] POS_PIXEL_END   = POS_W'(PIXEL_START + 2 * NUM_PIXELS);
    localparam logic [POS_W-1:0] POS_AMBIENT_LO  = POS_W'(AMBIENT_START);
    localparam logic [POS_W-1:0] POS_AMBIENT_HI  = POS_W'(AMBIENT_START + 1);
    localparam logic [POS_W-1:0] POS_CHECK_LO    = POS_W'(CHECKSUM_START);
    localparam logic [POS_W-1:0] POS_CHECK_HI    = POS_W'(CHECKSUM_START + 1);
    localparam logic [POS_W-1:0] POS_LAST        = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_SECOND_SYNC = POS_W'(1);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_H = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_V = 1'd1;

    typedef struct packed {
        logic mirror_h;
        logic mirror_v;
    } t_cfg;

    typedef struct packed {
        logic                        pixel_valid;
        logic [PIX_IDX_W-1:0]        pixel_index;
        logic signed [VAL_W-1:0]     pixel_value;
        logic                        frame_end;
        logic                        frame_good;
        logic                        sum_kind;
        logic signed [VAL_W-1:0]     ambient_value;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/tfd_if.sv =====
// tfd_if: channel interfaces for received bytes, results and configuration writes
`timescale 1ns / 1ps
`default_nettype none

interface tfd_rx_if;
    import tfd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfd_pix_if;
    import tfd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    pixel_valid;
    logic [PIX_IDX_W-1:0]    pixel_index;
    logic signed [VAL_W-1:0] pixel_value;
    logic                    frame_end;
    logic                    frame_good;
    logic                    sum_kind;
    logic signed [VAL_W-1:0] ambient_value;

    modport source (output valid, output pixel_valid, output pixel_index, output pixel_value,
                    output frame_end, output frame_good, output sum_kind,
                    output ambient_value, input ready);
    modport sink   (input valid, input pixel_valid, input pixel_index, input pixel_value,
                    input frame_end, input frame_good, input sum_kind,
                    input ambient_value, output ready);
endinterface

interface tfd_cfg_if;
    import tfd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tfd_frame_decoder.sv =====
// tfd_frame_decoder: sync hunt, frame position, running sums and pixel decode for one byte
`timescale 1ns / 1ps
`default_nettype none

module tfd_frame_decoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [tfd_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic                        i_strobe,
    input  wire tfd_pkg::t_cfg               i_cfg,
    output logic                             o_has_result,
    output tfd_pkg::t_result                 o_result
);
    import tfd_pkg::*;

    // frame state
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [SUM_W-1:0]  r_bsum,      n_bsum;
    logic [SUM_W-1:0]  r_wsum,      n_wsum;
    logic [BYTE_W-1:0] r_low_hold,  n_low_hold;
    logic [COL_W-1:0]  r_col,       n_col;
    logic [ROW_W-1:0]  r_row,       n_row;
    logic [VAL_W-1:0]  r_ambient,   n_ambient;
    logic [SUM_W-1:0]  r_expected,  n_expected;

    logic                 is_sync;
    logic                 hunting;
    logic                 live;
    logic                 pix;
    logic                 fend;
    logic                 byte_match;
    logic                 word_match;
    logic [SUM_W-1:0]     word;
    logic [COL_W-1:0]     base_col;
    logic [ROW_W-1:0]     base_row;
    logic [COL_W-1:0]     col_m;
    logic [ROW_W-1:0]     row_m;
    logic [PIX_IDX_W-1:0] pidx;

    // byte classification
    always_comb begin
        is_sync = (i_byte == SYNC_BYTE);
        hunting = (r_pos == '0);
        live    = is_sync || (!hunting && r_pos != POS_SECOND_SYNC);
        word    = {i_byte, r_low_hold};
        pix     = live && (r_pos >= POS_PIXEL_START) && (r_pos < POS_PIXEL_END)
                  && (r_pos[0] != POS_PIXEL_START[0]);
        fend    = live && (r_pos >= POS_LAST);
    end

    // pixel index after mirroring
    always_comb begin
        base_col = hunting ? '0 : r_col;
        base_row = hunting ? '0 : r_row;
        col_m    = i_cfg.mirror_h ? (COL_LAST - base_col) : base_col;
        row_m    = i_cfg.mirror_v ? (ROW_LAST - base_row) : base_row;
        pidx     = PIX_IDX_W'(row_m) * PIX_IDX_W'(COLUMNS) + PIX_IDX_W'(col_m);
    end

    // next frame state
    always_comb begin
        n_pos      = r_pos;
        n_bsum     = hunting ? '0 : r_bsum;
        n_wsum     = hunting ? '0 : r_wsum;
        n_low_hold = r_low_hold;
        n_col      = base_col;
        n_row      = base_row;
        n_ambient  = hunting ? '0 : r_ambient;
        n_expected = hunting ? '0 : r_expected;

        if (!live) begin
            // junk while hunting, or a broken second sync byte
            n_pos      = '0;
            n_bsum     = r_bsum;
            n_wsum     = r_wsum;
            n_col      = r_col;
            n_row      = r_row;
            n_ambient  = r_ambient;
            n_expected = r_expected;
        end else begin
            if (r_pos < POS_CHECK_LO) begin
                n_bsum = n_bsum + SUM_W'(i_byte);
                if (r_pos[0]) begin
                    n_wsum = n_wsum + word;
                end
            end
            if (r_pos == POS_AMBIENT_LO) begin
                n_ambient[BYTE_W-1:0] = i_byte;
            end
            if (r_pos == POS_AMBIENT_HI) begin
                n_ambient[VAL_W-1:BYTE_W] = i_byte;
            end
            if (r_pos == POS_CHECK_LO) begin
                n_expected[BYTE_W-1:0] = i_byte;
            end
            if (r_pos == POS_CHECK_HI) begin
                n_expected[SUM_W-1:BYTE_W] = i_byte;
            end
            if (pix) begin
                if (base_col == COL_LAST) begin
                    n_col = '0;
                    n_row = base_row + ROW_W'(1);
                end else begin
                    n_col = base_col + COL_W'(1);
                end
            end
            n_low_hold = i_byte;
            n_pos      = fend ? '0 : r_pos + POS_W'(1);
        end
    end

    // checksum verdict and result beat
    always_comb begin
        byte_match = (n_bsum == n_expected);
        word_match = (n_wsum == n_expected);

        o_has_result           = pix || fend;
        o_result.pixel_valid   = pix;
        o_result.pixel_index   = pix ? pidx : '0;
        o_result.pixel_value   = pix ? $signed(word) : '0;
        o_result.frame_end     = fend;
        o_result.frame_good    = fend && (byte_match || word_match);
        o_result.sum_kind      = fend && !byte_match && word_match;
        o_result.ambient_value = fend ? $signed(n_ambient) : '0;
    end

    // position is control state, the rest is cleared at each sync
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_strobe) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_strobe) begin
            r_bsum     <= n_bsum;
            r_wsum     <= n_wsum;
            r_low_hold <= n_low_hold;
            r_col      <= n_col;
            r_row      <= n_row;
            r_ambient  <= n_ambient;
            r_expected <= n_expected;
        end
    end

    // frame end always returns to the sync hunt
    a_fend_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe && o_has_result && o_result.frame_end |=> r_pos == '0)
        else $error("position not cleared after frame end");

    // position never runs past the last byte of a frame
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("byte position past frame length");

    // a broken second sync byte drops back to hunting
    a_second_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe && r_pos == POS_SECOND_SYNC && !is_sync |=> r_pos == '0)
        else $error("broken sync not dropped");

endmodule

`default_nettype wire

// ===== hdl/thermal_frame_deframer.sv =====
// thermal_frame_deframer: top level with input stage, result register and mirror registers
//
//   channel  dir  beat                        handshake
//   i_rx     in   one received serial byte    valid / ready
//   o_pix    out  pixel and/or frame verdict  valid / ready
//   i_cfg    in   register index and data     valid / ready (always ready)
//
// one byte per cycle sustained while o_pix keeps up; a byte passes input then result register
// a byte that completes a result stalls in the input register only while the previous
// result still waits for o_pix.ready
// bytes that give no result pass the decode stage even while the result register is full
// reset (synchronous, active low) clears the sync hunt, both mirror bits and all valids
`timescale 1ns / 1ps
`default_nettype none

module thermal_frame_deframer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tfd_rx_if.sink     i_rx,
    tfd_pix_if.source  o_pix,
    tfd_cfg_if.sink    i_cfg
);
    import tfd_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_cfg              r_cfg;

    logic    has_result;
    t_result result;
    logic    out_free;
    logic    advance;

    tfd_frame_decoder u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (r_in_byte),
        .i_strobe     (advance),
        .i_cfg        (r_cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // stage handshake
    always_comb begin
        out_free   = !r_out_valid || o_pix.ready;
        advance    = r_in_valid && (out_free || !has_result);
        i_rx.ready = !r_in_valid || advance;
        i_cfg.ready = 1'b1;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out <= result;
        end
    end

    // mirror registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_MIRROR_H: r_cfg.mirror_h <= i_cfg.data[0];
                CFG_MIRROR_V: r_cfg.mirror_v <= i_cfg.data[0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // result beat
    always_comb begin
        o_pix.valid         = r_out_valid;
        o_pix.pixel_valid   = r_out.pixel_valid;
        o_pix.pixel_index   = r_out.pixel_index;
        o_pix.pixel_value   = r_out.pixel_value;
        o_pix.frame_end     = r_out.frame_end;
        o_pix.frame_good    = r_out.frame_good;
        o_pix.sum_kind      = r_out.sum_kind;
        o_pix.ambient_value = r_out.ambient_value;
    end

    // every result beat carries a pixel or a frame verdict
    a_out_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.pixel_valid || r_out.frame_end))
        else $error("empty result beat");

    // a word sum match is only reported on a good frame
    a_kind_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.sum_kind |-> r_out.frame_good && r_out.frame_end)
        else $error("sum kind without good frame");

    // a held byte stays put until the decode stage takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte))
        else $error("held input byte lost");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && has_result |-> out_free)
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench of the thermal frame deframer
`timescale 1ns / 1ps

module tb_top;
    import tfd_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int LONG_HOLD     = 400;

    typedef enum int {
        CHK_BYTE_TOTAL,
        CHK_WORD_TOTAL,
        CHK_BOTH_SUMS,
        CHK_NONE
    } trailer_e;

    // predicts pixels and frame verdicts from accepted bytes and checks the result beats
    class deframe_checker;
        logic                  mirror_h = 1'b0;
        logic                  mirror_v = 1'b0;
        logic [POS_W-1:0]      frame_pos = '0;
        logic [SUM_W-1:0]      run_bsum = '0;
        logic [SUM_W-1:0]      run_wsum = '0;
        logic [BYTE_W-1:0]     prev_byte = '0;
        int                    col_cnt = 0;
        int                    row_cnt = 0;
        logic [VAL_W-1:0]      ambient = '0;
        logic [SUM_W-1:0]      check_word = '0;
        t_result               pending_results[$];
        int                    errors = 0;

        function void clear_frame();
            frame_pos  = '0;
            run_bsum   = '0;
            run_wsum   = '0;
            prev_byte  = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            ambient    = '0;
            check_word = '0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MIRROR_H: mirror_h = val[0];
                CFG_MIRROR_V: mirror_v = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // one accepted byte: advance the frame and queue the result it causes
        function void note_byte(logic [BYTE_W-1:0] b);
            int      pos;
            int      off;
            int      cc;
            int      rr;
            bit      fire;
            bit      byte_hit;
            bit      word_hit;
            t_result r;
            pos  = frame_pos;
            r    = '0;
            fire = 1'b0;

            // sync hunt: stray bytes and a broken second sync byte are dropped
            if (pos == 0) begin
                if (b != SYNC_BYTE) return;
                clear_frame();
            end else if (pos == 1 && b != SYNC_BYTE) begin
                frame_pos = '0;
                return;
            end

            // running sums over everything ahead of the checksum
            if (pos < CHECKSUM_START) begin
                run_bsum = run_bsum + b;
                if (pos % 2 == 1) run_wsum = run_wsum + {b, prev_byte};
            end

            // ambient and trailing checksum, low byte first
            if (pos == AMBIENT_START) ambient[7:0] = b;
            if (pos == AMBIENT_START + 1) ambient[15:8] = b;
            if (pos == CHECKSUM_START) check_word[7:0] = b;
            if (pos == CHECKSUM_START + 1) check_word[15:8] = b;

            // pixel completes on its high byte
            if (pos >= PIXEL_START) begin
                off = pos - PIXEL_START;
                if (off < 2 * NUM_PIXELS && off % 2 == 1) begin
                    cc = mirror_h ? COLUMNS - 1 - col_cnt : col_cnt;
                    rr = mirror_v ? ROWS - 1 - row_cnt : row_cnt;
                    r.pixel_valid = 1'b1;
                    r.pixel_index = PIX_IDX_W'(rr * COLUMNS + cc);
                    r.pixel_value = {b, prev_byte};
                    fire = 1'b1;
                    col_cnt++;
                    if (col_cnt >= COLUMNS) begin
                        col_cnt = 0;
                        row_cnt++;
                    end
                end
            end

            prev_byte = b;

            // last byte: verdict, byte sum takes precedence
            if (pos + 1 >= FRAME_BYTES) begin
                byte_hit        = (run_bsum == check_word);
                word_hit        = (run_wsum == check_word);
                r.frame_end     = 1'b1;
                r.frame_good    = byte_hit || word_hit;
                r.sum_kind      = !byte_hit && word_hit;
                r.ambient_value = ambient;
                frame_pos       = '0;
                fire            = 1'b1;
            end else begin
                frame_pos = POS_W'(pos + 1);
            end

            if (fire) pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [31:0] want_v,
                                    logic signed [31:0] got_v);
            if (got_v !== want_v) begin
                if (errors < MAX_REPORTS)
                    $display("mismatch in %s: expected %0d, got %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        // one result beat against the oldest prediction
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("unexpected result: pixel %0b index %0d value %0d frame_end %0b",
                             got.pixel_valid, got.pixel_index, got.pixel_value, got.frame_end);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("pixel_valid", want.pixel_valid, got.pixel_valid);
            compare_field("pixel_index", want.pixel_index, got.pixel_index);
            compare_field("pixel_value", want.pixel_value, got.pixel_value);
            compare_field("frame_end", want.frame_end, got.frame_end);
            compare_field("frame_good", want.frame_good, got.frame_good);
            compare_field("sum_kind", want.sum_kind, got.sum_kind);
            compare_field("ambient_value", want.ambient_value, got.ambient_value);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tfd_rx_if  rx_if();
    tfd_pix_if pix_if();
    tfd_cfg_if cfg_if();

    thermal_frame_deframer i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if.sink),
        .o_pix   (pix_if.source),
        .i_cfg   (cfg_if.sink)
    );

    deframe_checker    sb;
    int                idle_pct;
    int                stall_pct;
    int                hold_off_cycles;
    int                cycles;
    logic [BYTE_W-1:0] frame_bytes [FRAME_BYTES];

    // stray bytes and broken sync pairs, ending in the hunt state
    logic [BYTE_W-1:0] probe_bytes [16] = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'h5A, 8'hA5,
                                           8'h5A, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
                                           8'h7F, 8'h5B, 8'h59, 8'hFE};

    // per phase idling and mirror setting
    int   src_idle [4] = '{0, 48, 0, 23};
    int   snk_idle [4] = '{0, 0, 48, 23};
    logic mir_h [4]    = '{1'b0, 1'b1, 1'b0, 1'b1};
    logic mir_v [4]    = '{1'b0, 1'b0, 1'b1, 1'b1};

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // result side: ready with random stalls and one long hold, beats checked at the edge
    initial begin
        t_result got;
        pix_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_cycles > 0) begin
                pix_if.ready = 1'b0;
                hold_off_cycles--;
            end else begin
                pix_if.ready = ($urandom_range(99) >= stall_pct);
            end
            @(posedge clk);
            if (rst_n && pix_if.valid && pix_if.ready) begin
                got.pixel_valid   = pix_if.pixel_valid;
                got.pixel_index   = pix_if.pixel_index;
                got.pixel_value   = pix_if.pixel_value;
                got.frame_end     = pix_if.frame_end;
                got.frame_good    = pix_if.frame_good;
                got.sum_kind      = pix_if.sum_kind;
                got.ambient_value = pix_if.ambient_value;
                sb.check_result(got);
            end
        end
    end

    task automatic send_byte(logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            rx_if.valid = 1'b0;
        end
        @(negedge clk);
        rx_if.valid   = 1'b1;
        rx_if.rx_byte = b;
        do @(posedge clk); while (!rx_if.ready);
        sb.note_byte(b);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge clk); while (!cfg_if.ready);
        sb.set_register(idx, val);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // noise between frames; a lone sync byte is always broken by a non-sync byte
    task automatic send_noise(int count);
        logic [BYTE_W-1:0] b;
        repeat (count) begin
            b = ($urandom_range(3) == 0) ? SYNC_BYTE : BYTE_W'($urandom);
            send_byte(b);
            if (b == SYNC_BYTE) begin
                do b = BYTE_W'($urandom); while (b == SYNC_BYTE);
                send_byte(b);
            end
        end
    endtask

    // fills frame_bytes with a frame whose trailer matches the chosen sum(s)
    function automatic void build_frame(trailer_e kind);
        logic [SUM_W-1:0] bsum;
        logic [SUM_W-1:0] wsum;
        logic [SUM_W-1:0] chk;
        logic [VAL_W-1:0] word;
        int               hi_total;
        int               goal;
        int               delta;
        int               step;
        int               p;
        frame_bytes[0] = SYNC_BYTE;
        frame_bytes[1] = SYNC_BYTE;
        for (p = 2; p < FRAME_BYTES; p++) frame_bytes[p] = BYTE_W'($urandom);

        // pixels and ambient with a share of extreme values
        for (p = PIXEL_START; p <= PIXEL_START + 2 * NUM_PIXELS; p += 2) begin
            case ($urandom_range(7))
                0: word = 16'h8000;
                1: word = 16'h7FFF;
                2: word = 16'h0000;
                3: word = 16'hFFFF;
                default: word = VAL_W'($urandom);
            endcase
            if (p == PIXEL_START + 2 * NUM_PIXELS) begin
                frame_bytes[AMBIENT_START]     = word[7:0];
                frame_bytes[AMBIENT_START + 1] = word[15:8];
            end else begin
                frame_bytes[p]     = word[7:0];
                frame_bytes[p + 1] = word[15:8];
            end
        end

        // both sums agree when the high bytes sum to a multiple of 65536
        if (kind == CHK_BOTH_SUMS) begin
            hi_total = 0;
            for (p = 1; p < CHECKSUM_START; p += 2) hi_total += frame_bytes[p];
            goal  = (hi_total < 98304) ? 65536 : 131072;
            delta = goal - hi_total;
            for (p = 3; p < CHECKSUM_START && delta != 0; p += 2) begin
                if (delta > 0) begin
                    step = 255 - frame_bytes[p];
                    if (step > delta) step = delta;
                    frame_bytes[p] = BYTE_W'(frame_bytes[p] + step);
                    delta -= step;
                end else begin
                    step = frame_bytes[p];
                    if (step > -delta) step = -delta;
                    frame_bytes[p] = BYTE_W'(frame_bytes[p] - step);
                    delta += step;
                end
            end
        end

        bsum = '0;
        wsum = '0;
        for (p = 0; p < CHECKSUM_START; p++) begin
            bsum = bsum + frame_bytes[p];
            if (p % 2 == 1) wsum = wsum + {frame_bytes[p], frame_bytes[p - 1]};
        end

        case (kind)
            CHK_BYTE_TOTAL: chk = bsum;
            CHK_WORD_TOTAL: chk = wsum;
            CHK_BOTH_SUMS:  chk = bsum;
            default: begin
                chk = SUM_W'($urandom);
                while (chk == bsum || chk == wsum) chk = chk + 1'b1;
            end
        endcase
        frame_bytes[CHECKSUM_START]     = chk[7:0];
        frame_bytes[CHECKSUM_START + 1] = chk[15:8];
    endfunction

    task automatic send_frame(trailer_e kind);
        build_frame(kind);
        foreach (frame_bytes[p]) send_byte(frame_bytes[p]);
    endtask

    // stop offering, wait for every predicted beat, then let the pipeline empty
    task automatic drain();
        @(negedge clk);
        rx_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // stimulus
    initial begin
        int r;
        sb              = new();
        rst_n           = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        hold_off_cycles = 0;
        rx_if.valid     = 1'b0;
        rx_if.rx_byte   = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = src_idle[ph];
            stall_pct = snk_idle[ph];
            write_reg(CFG_MIRROR_H, mir_h[ph]);
            write_reg(CFG_MIRROR_V, mir_v[ph]);
            if (ph == 0) begin
                // directed: stray bytes, broken syncs, one frame of each verdict
                foreach (probe_bytes[i]) send_byte(probe_bytes[i]);
                hold_off_cycles = LONG_HOLD;
                send_frame(CHK_BYTE_TOTAL);
                send_frame(CHK_WORD_TOTAL);
                send_frame(CHK_BOTH_SUMS);
                send_frame(CHK_NONE);
            end else begin
                send_noise($urandom_range(4, 20));
                r = $urandom_range(99);
                if (r < 35)      send_frame(CHK_BYTE_TOTAL);
                else if (r < 70) send_frame(CHK_WORD_TOTAL);
                else if (r < 80) send_frame(CHK_BOTH_SUMS);
                else             send_frame(CHK_NONE);
                send_noise($urandom_range(0, 10));
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tfd_pkg.sv
hdl/tfd_if.sv
hdl/tfd_frame_decoder.sv
hdl/thermal_frame_deframer.sv
tb/tb_top.sv
